FILE: src/pcf1_pkg.sv
// ----------------------------------------------------------------------------
// pcf1_pkg
// Shared constants and types of the pairwise clustering F1 evaluator.
// ----------------------------------------------------------------------------
package pcf1_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int LABEL_BITS = 16;

  localparam int ID_W    = 16;
  localparam int Q_W     = 16;
  localparam int COUNT_W = 19;
  localparam int ADDR_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int DEN_W   = COUNT_W + 2;
  localparam int REM_W   = DEN_W + 1;
  localparam int STEP_W  = $clog2(Q_W);

  localparam logic [ID_W-1:0] LABEL_MASK =
    (LABEL_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << LABEL_BITS) - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [Q_W-1:0]     Q_ONE     = Q_W'(1 << (Q_W - 1));
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(MAX_ITEMS);

  typedef struct packed {
    logic [ID_W-1:0] truth;
    logic [ID_W-1:0] clus;
  } entry_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: src/pcf1_in_if.sv
// ----------------------------------------------------------------------------
// pcf1_in_if
// Request channel carrying one paper: labels, clustered flag and last mark.
// ----------------------------------------------------------------------------
interface pcf1_in_if;
  logic                      valid;
  logic                      ready;
  logic [pcf1_pkg::ID_W-1:0] true_label;
  logic [pcf1_pkg::ID_W-1:0] cluster_id;
  logic                      in_result;
  logic                      last;

  modport source (output valid, true_label, cluster_id, in_result, last, input ready);
  modport sink   (input valid, true_label, cluster_id, in_result, last, output ready);
endinterface

FILE: src/pcf1_out_if.sv
// ----------------------------------------------------------------------------
// pcf1_out_if
// Result channel carrying pair counts and Q1.15 precision, recall and F1.
// ----------------------------------------------------------------------------
interface pcf1_out_if;
  logic                         valid;
  logic                         ready;
  logic [pcf1_pkg::Q_W-1:0]     precision;
  logic [pcf1_pkg::Q_W-1:0]     recall;
  logic [pcf1_pkg::Q_W-1:0]     f_score;
  logic [pcf1_pkg::COUNT_W-1:0] true_pos;
  logic [pcf1_pkg::COUNT_W-1:0] true_neg;
  logic [pcf1_pkg::COUNT_W-1:0] false_pos;
  logic [pcf1_pkg::COUNT_W-1:0] false_neg;
  logic                         overflow;

  modport source (output valid, precision, recall, f_score, true_pos, true_neg,
                  false_pos, false_neg, overflow, input ready);
  modport sink   (input valid, precision, recall, f_score, true_pos, true_neg,
                  false_pos, false_neg, overflow, output ready);
endinterface

FILE: src/pcf1_store.sv
// ----------------------------------------------------------------------------
// pcf1_store
// Item memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pcf1_store (
  input  logic                 clk,
  input  pcf1_pkg::store_req_t req,
  output pcf1_pkg::entry_t     rd_data
);
  import pcf1_pkg::*;

  entry_t mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end
endmodule

FILE: src/pcf1_div.sv
// ----------------------------------------------------------------------------
// pcf1_div
// Restoring divider: floor(num * 2^15 / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcf1_div (
  input  logic               clk,
  input  logic               rst,
  input  pcf1_pkg::div_req_t req,
  output pcf1_pkg::div_rsp_t rsp
);
  import pcf1_pkg::*;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t           state;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_next;
  logic [REM_W-1:0]  trial;
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] step;
  logic [Q_W-1:0]    quot;
  logic              done;
  logic              ge;

  // first step takes the integer bit, later steps shift in a zero
  always_comb begin
    trial    = (step == '0) ? rem : {rem[REM_W-2:0], 1'b0};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? trial - {1'b0, den} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            rem   <= {1'b0, req.num};
            den   <= req.den;
            quot  <= '0;
            step  <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem  <= rem_next;
          quot <= {quot[Q_W-2:0], ge};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(Q_W - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state == D_RUN);
  assign rsp.done = done;
  assign rsp.quot = quot;
endmodule

FILE: src/pairwise_cluster_f1_top.sv
// ----------------------------------------------------------------------------
// pairwise_cluster_f1_top
// Pairwise clustering evaluation: pair counts and Q1.15 precision, recall, F1.
//
// items is the request channel, one paper per request; results carries one
// result per request marked last. A clustered paper is written to the item
// memory and compared against every paper stored before it, one memory read
// per cycle; an unclustered or dropped paper is neither stored nor compared.
// On a last request with true positives the shared divider runs three times,
// for precision, recall and F1; with none, recall and F1 are zero and
// precision is one only if no false positive was seen. Once MAX_ITEMS papers
// are held, further clustered papers are dropped and overflow is reported.
// The result sits in an output register; new requests are taken while it
// waits. A last request that finishes while the previous result still waits
// holds until the receiver takes it. Reset clears counts and flags at once;
// the item memory needs no clearing. After each result the block starts a
// fresh set.
// ----------------------------------------------------------------------------
module pairwise_cluster_f1_top (
  input logic        clk,
  input logic        rst,
  pcf1_in_if.sink    items,
  pcf1_out_if.source results
);
  import pcf1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CHECK, S_DIV_START, S_DIV_WAIT, S_OUT
  } state_t;

  typedef enum logic [1:0] {Q_PRE, Q_REC, Q_F1} qsel_t;

  state_t            state;
  qsel_t             qsel;
  logic [CNT_W-1:0]  item_count;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  idx;
  logic              cmp_valid;
  logic [ID_W-1:0]   truth;
  logic [ID_W-1:0]   clus;
  logic              is_last;
  logic [COUNT_W-1:0] count_tp, count_tn, count_fp, count_fn;
  logic              overflow_seen;
  logic [Q_W-1:0]    pre, rec, f1;
  logic              out_valid;

  store_req_t        store_req;
  entry_t            rd_data;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              accept;
  logic              room;
  logic              load_out;
  logic              same_t, same_c;
  logic [DEN_W-1:0]  tp_x, fp_x, fn_x;

  assign accept   = items.valid && items.ready;
  assign room     = item_count < CNT_FULL;
  assign load_out = (state == S_OUT) && (!out_valid || results.ready);
  assign items.ready = (state == S_IDLE);

  always_comb begin
    store_req.wr_en         = accept && items.in_result && room;
    store_req.wr_addr       = item_count[ADDR_W-1:0];
    store_req.wr_data.truth = items.true_label & LABEL_MASK;
    store_req.wr_data.clus  = items.cluster_id;
    store_req.rd_en         = (state == S_SCAN) && (idx < limit);
    store_req.rd_addr       = idx[ADDR_W-1:0];
  end

  assign same_t = rd_data.truth == truth;
  assign same_c = rd_data.clus == clus;

  assign tp_x = DEN_W'(count_tp);
  assign fp_x = DEN_W'(count_fp);
  assign fn_x = DEN_W'(count_fn);

  always_comb begin
    div_req.start = (state == S_DIV_START);
    unique case (qsel)
      Q_PRE: begin
        div_req.num = tp_x;
        div_req.den = tp_x + fp_x;
      end
      Q_REC: begin
        div_req.num = tp_x;
        div_req.den = tp_x + fn_x;
      end
      default: begin
        div_req.num = {tp_x[DEN_W-2:0], 1'b0};
        div_req.den = {tp_x[DEN_W-2:0], 1'b0} + fp_x + fn_x;
      end
    endcase
  end

  pcf1_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

  pcf1_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      qsel          <= Q_PRE;
      item_count    <= '0;
      idx           <= '0;
      limit         <= '0;
      cmp_valid     <= 1'b0;
      count_tp      <= '0;
      count_tn      <= '0;
      count_fp      <= '0;
      count_fn      <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      cmp_valid <= store_req.rd_en;

      if (cmp_valid) begin
        if (same_t && same_c) begin
          if (count_tp != COUNT_MAX) count_tp <= count_tp + COUNT_W'(1);
        end else if (!same_t && !same_c) begin
          if (count_tn != COUNT_MAX) count_tn <= count_tn + COUNT_W'(1);
        end else if (!same_t) begin
          if (count_fp != COUNT_MAX) count_fp <= count_fp + COUNT_W'(1);
        end else begin
          if (count_fn != COUNT_MAX) count_fn <= count_fn + COUNT_W'(1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            truth   <= items.true_label & LABEL_MASK;
            clus    <= items.cluster_id;
            is_last <= items.last;
            state   <= S_CHECK;
            if (items.in_result) begin
              if (!room) begin
                overflow_seen <= 1'b1;
              end else begin
                limit      <= item_count;
                item_count <= item_count + CNT_W'(1);
                idx        <= '0;
                state      <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (store_req.rd_en) begin
            idx <= idx + CNT_W'(1);
          end else if (!cmp_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!is_last) begin
            state <= S_IDLE;
          end else if (count_tp == '0) begin
            pre   <= (count_fp == '0) ? Q_ONE : '0;
            rec   <= '0;
            f1    <= '0;
            state <= S_OUT;
          end else begin
            qsel  <= Q_PRE;
            state <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            unique case (qsel)
              Q_PRE: begin
                pre   <= div_rsp.quot;
                qsel  <= Q_REC;
                state <= S_DIV_START;
              end
              Q_REC: begin
                rec   <= div_rsp.quot;
                qsel  <= Q_F1;
                state <= S_DIV_START;
              end
              default: begin
                f1    <= div_rsp.quot;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (load_out) begin
            results.precision <= pre;
            results.recall    <= rec;
            results.f_score   <= f1;
            results.true_pos  <= count_tp;
            results.true_neg  <= count_tn;
            results.false_pos <= count_fp;
            results.false_neg <= count_fn;
            results.overflow  <= overflow_seen;
            item_count        <= '0;
            count_tp          <= '0;
            count_tn          <= '0;
            count_fp          <= '0;
            count_fn          <= '0;
            overflow_seen     <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid = out_valid;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_FULL)
    else $error("item count beyond capacity");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == S_SCAN))
    else $error("compare outside scan");

  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (item_count == '0) && out_valid && !overflow_seen)
    else $error("state not cleared after result");
`endif
endmodule
